>>> rtl/core/epoch_seconds_to_calendar_top_macros.svh
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top_macros.svh
// Assertion macros for the epoch-to-calendar converter. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define ESC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esc assertion failed");

// consequent must hold in the cycle after the antecedent
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esc assertion failed");

`else

`define ESC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Types, widths and reciprocal constants shared by the epoch-to-calendar
// converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  // field widths
  localparam int unsigned SECS_W  = 38;
  localparam int unsigned NS_W    = 30;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // internal widths
  localparam int unsigned DAYS_W  = 22;   // days since epoch and shifted day
  localparam int unsigned TOD_W   = 17;   // seconds of day
  localparam int unsigned TMIN_W  = 11;   // minutes of day
  localparam int unsigned ERA_W   = 5;
  localparam int unsigned DOE_W   = 18;   // day of era
  localparam int unsigned YOE_W   = 9;    // year of era
  localparam int unsigned DOY_W   = 9;    // day of March-based year
  localparam int unsigned MP_W    = 4;    // month index, 0 = March

  // pipeline depth: 2 stages for day split, 8 stages in the date unit
  localparam int unsigned PIPE_STAGES = 10;
  localparam int unsigned DATE_STAGES = 8;

  localparam logic [SECS_W-1:0] MAX_EPOCH_SECONDS = 38'd253402300799;

  localparam int unsigned SECS_PER_DAY     = 86400;
  localparam int unsigned SECS_PER_MIN     = 60;
  localparam int unsigned MINS_PER_HOUR    = 60;
  localparam int unsigned DAYS_PER_YEAR    = 365;
  localparam int unsigned YEARS_PER_ERA    = 400;
  localparam int unsigned DAYS_PER_ERA     = 146097;
  localparam int unsigned EPOCH_SHIFT_DAYS = 719468;
  localparam int unsigned DAYS_PER_CENT    = 36524;
  localparam int unsigned ERA_LAST_DAY     = 146096;

  // Reciprocals, rounded up: floor(x*M >> K) == x / d over the used range.
  // secs >> 7, then / 675 gives secs / 86400
  localparam int unsigned DAY_PRE_SHIFT = 7;
  localparam logic [31:0] DAY_RECIP     = 32'd3257812231;
  localparam int unsigned DAY_SHIFT     = 41;
  // / 60 for values below 86400
  localparam logic [17:0] SIXTY_RECIP   = 18'd139811;
  localparam int unsigned SIXTY_SHIFT   = 23;
  // / 146097 for shifted day counts
  localparam logic [22:0] ERA_RECIP     = 23'd7525902;
  localparam int unsigned ERA_SHIFT     = 40;
  // (doe >> 2) / 365 gives doe / 1460
  localparam logic [15:0] Q4Y_RECIP     = 16'd45965;
  localparam int unsigned Q4Y_SHIFT     = 24;
  // / 365 for values below 146097
  localparam logic [17:0] YEAR_RECIP    = 18'd183860;
  localparam int unsigned YEAR_SHIFT    = 26;
  // / 153 for values below 1832
  localparam logic [10:0] M153_RECIP    = 11'd1714;
  localparam int unsigned M153_SHIFT    = 18;

  // month index at which the calendar year rolls over (January)
  localparam logic [MP_W-1:0] MP_JANUARY = 4'd10;

  typedef struct packed {
    logic [SECS_W-1:0] epoch_seconds;
    logic [NS_W-1:0]   nanoseconds;
  } in_word_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day_of_month;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [NS_W-1:0]   nanoseconds_out;
  } out_word_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DOM_W-1:0]  day_of_month;
  } ymd_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } hms_t;

  // first day of each March-based month within the year
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/esc_chan_if.sv
// ----------------------------------------------------------------------------
// esc_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface esc_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/core/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Seconds since 1970-01-01 00:00:00 to Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Takes one word per clock unless the pipeline is stalled, and returns one
// word per input. The pipeline has ten register stages. Each stage holds at
// most one constant-reciprocal multiply or a short add/subtract step. Every
// stage stalls only when it is full and the stage after it cannot advance,
// so input keeps flowing into empty stages while a result waits at the
// output. Seconds above 253402300799 are clamped to 9999-12-31 23:59:59.
// Nanoseconds are copied through without a range check.
`include "epoch_seconds_to_calendar_top_macros.svh"

module epoch_seconds_to_calendar_top (
  input  logic       clk,
  input  logic       rst_n,
  esc_chan_if.sink   in_chan,
  esc_chan_if.source out_chan
);
  import esc_pkg::*;

  // per-stage valid bits and load enables
  logic [PIPE_STAGES:1] v_r;
  logic [PIPE_STAGES:1] en;

  // payload registers
  logic [NS_W-1:0]   ns_r [1:PIPE_STAGES];
  hms_t              hms_r [6:PIPE_STAGES];
  logic [SECS_W-1:0] secs1_r, secs2_r;
  logic [DAYS_W-1:0] days2_r;
  logic [TOD_W-1:0]  tod3_r, tod4_r;
  logic [TMIN_W-1:0] tmin4_r, tmin5_r;
  logic [HOUR_W-1:0] hour5_r;
  logic [SEC_W-1:0]  sec5_r;

  logic [SECS_W-1:0] secs_nxt;
  logic [62:0]       day_prod;
  logic [38:0]       day_secs;
  logic [SECS_W-1:0] tod_full;
  logic [34:0]       tmin_prod;
  logic [TOD_W-1:0]  tmin_secs;
  logic [TOD_W-1:0]  sec_full;
  logic [28:0]       hour_prod;
  logic [TMIN_W-1:0] hour_mins;
  logic [TMIN_W-1:0] min_full;
  ymd_t              ymd;
  in_word_t          in_word;
  out_word_t         out_word;

  assign in_word = in_chan.data;

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[PIPE_STAGES] = !v_r[PIPE_STAGES] || out_chan.ready;
    for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_chan.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_chan.valid;
      end
      for (int k = 2; k <= PIPE_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // S1: clamp to the last second of year 9999
  assign secs_nxt = (in_word.epoch_seconds > MAX_EPOCH_SECONDS) ?
                    MAX_EPOCH_SECONDS : in_word.epoch_seconds;

  // S2: day count, secs / 86400 as (secs >> 7) / 675
  assign day_prod = 63'(secs1_r[SECS_W-1:DAY_PRE_SHIFT]) * 63'(DAY_RECIP);

  // S3: seconds of day
  assign day_secs = 39'(days2_r) * 39'(SECS_PER_DAY);
  assign tod_full = secs2_r - day_secs[SECS_W-1:0];

  // S4: minutes of day
  assign tmin_prod = 35'(tod3_r) * 35'(SIXTY_RECIP);

  // S5: second of minute and hour of day
  assign tmin_secs = TOD_W'(tmin4_r) * TOD_W'(SECS_PER_MIN);
  assign sec_full  = tod4_r - tmin_secs;
  assign hour_prod = 29'(tmin4_r) * 29'(SIXTY_RECIP);

  // S6: minute of hour
  assign hour_mins = TMIN_W'(hour5_r) * TMIN_W'(MINS_PER_HOUR);
  assign min_full  = tmin5_r - hour_mins;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      secs1_r  <= secs_nxt;
      ns_r[1]  <= in_word.nanoseconds;
    end
    if (en[2]) begin
      secs2_r <= secs1_r;
      days2_r <= day_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
    end
    if (en[3]) begin
      tod3_r <= tod_full[TOD_W-1:0];
    end
    if (en[4]) begin
      tod4_r  <= tod3_r;
      tmin4_r <= tmin_prod[SIXTY_SHIFT+TMIN_W-1:SIXTY_SHIFT];
    end
    if (en[5]) begin
      tmin5_r <= tmin4_r;
      sec5_r  <= sec_full[SEC_W-1:0];
      hour5_r <= hour_prod[SIXTY_SHIFT+HOUR_W-1:SIXTY_SHIFT];
    end
    if (en[6]) begin
      hms_r[6].hour   <= hour5_r;
      hms_r[6].minute <= min_full[MIN_W-1:0];
      hms_r[6].second <= sec5_r;
    end
    for (int k = 2; k <= PIPE_STAGES; k++) begin
      if (en[k]) begin
        ns_r[k] <= ns_r[k-1];
      end
    end
    for (int k = 7; k <= PIPE_STAGES; k++) begin
      if (en[k]) begin
        hms_r[k] <= hms_r[k-1];
      end
    end
  end

  // date path, stages S3 through S10
  esc_date u_date (
    .clk    (clk),
    .en     (en[PIPE_STAGES:3]),
    .days_i (days2_r),
    .ymd_o  (ymd)
  );

  // result word
  always_comb begin
    out_word.year            = ymd.year;
    out_word.month           = ymd.month;
    out_word.day_of_month    = ymd.day_of_month;
    out_word.hour            = hms_r[PIPE_STAGES].hour;
    out_word.minute          = hms_r[PIPE_STAGES].minute;
    out_word.second          = hms_r[PIPE_STAGES].second;
    out_word.nanoseconds_out = ns_r[PIPE_STAGES];
  end

  assign out_chan.valid = v_r[PIPE_STAGES];
  assign out_chan.data  = out_word;

  // checks
  `ESC_ASSERT_SAME(a_full_stall_blocks_in, clk, rst_n, (&v_r) && !out_chan.ready, !in_chan.ready)
  `ESC_ASSERT_SAME(a_date_range, clk, rst_n, out_chan.valid, (out_word.month >= 4'd1) && (out_word.month <= 4'd12) && (out_word.day_of_month >= 5'd1) && (out_word.year >= 14'd1970) && (out_word.year <= 14'd9999))
  `ESC_ASSERT_SAME(a_time_range, clk, rst_n, out_chan.valid, (out_word.hour < 5'd24) && (out_word.minute < 6'd60) && (out_word.second < 6'd60))
  `ESC_ASSERT_NEXT(a_empty_takes_in, clk, rst_n, !v_r[1], in_chan.ready || v_r[1])

endmodule

>>> rtl/core/esc_date.sv
// ----------------------------------------------------------------------------
// esc_date
// Eight-stage date unit: day count since epoch to year, month and day,
// counting in 400-year eras that start on March 1.
// ----------------------------------------------------------------------------
module esc_date (
  input  logic                               clk,
  input  logic [esc_pkg::DATE_STAGES-1:0]    en,
  input  logic [esc_pkg::DAYS_W-1:0]         days_i,
  output esc_pkg::ymd_t                      ymd_o
);
  import esc_pkg::*;

  // stage registers
  logic [DAYS_W-1:0] z1_r, z2_r;
  logic [ERA_W-1:0]  era2_r;
  logic [DOE_W-1:0]  doe3_r, doe4_r, doe5_r;
  logic [YEAR_W-1:0] ybase3_r, ybase4_r, ybase5_r, ybase6_r;
  logic [6:0]        q4y4_r;
  logic [2:0]        cent4_r;
  logic              last4_r;
  logic [YOE_W-1:0]  yoe5_r, yoe6_r;
  logic [DOY_W-1:0]  doy6_r, doy7_r;
  logic [MP_W-1:0]   mp7_r;
  logic [YEAR_W-1:0] ysum7_r;
  ymd_t              ymd8_r;

  // combinational next values
  logic [DAYS_W-1:0]     z_nxt;
  logic [44:0]           era_prod;
  logic [22:0]           era_days;
  logic [DAYS_W-1:0]     doe_full;
  logic [YEAR_W-1:0]     ybase_nxt;
  logic [31:0]           q4y_prod;
  logic [2:0]            cent_nxt;
  logic [DOE_W-1:0]      n_val;
  logic [35:0]           yoe_prod;
  logic [1:0]            yoe_cent;
  logic [DOE_W-1:0]      yoe_days;
  logic [DOE_W-1:0]      doy_full;
  logic [10:0]           mp_arg;
  logic [21:0]           mp_prod;
  logic [DOY_W-1:0]      dom_full;
  logic [MP_W-1:0]       mon_nxt;
  logic                  jan_feb;

  // D1: shift origin to 0000-03-01
  assign z_nxt = days_i + DAYS_W'(EPOCH_SHIFT_DAYS);

  // D2: era by reciprocal
  assign era_prod = 45'(z1_r) * 45'(ERA_RECIP);

  // D3: day of era and era base year
  assign era_days  = 23'(era2_r) * 23'(DAYS_PER_ERA);
  assign doe_full  = z2_r - era_days[DAYS_W-1:0];
  assign ybase_nxt = YEAR_W'(era2_r) * YEAR_W'(YEARS_PER_ERA);

  // D4: leap corrections: four-year count, century count, last day of era
  assign q4y_prod = 32'(doe3_r[DOE_W-1:2]) * 32'(Q4Y_RECIP);
  assign cent_nxt = 3'(doe3_r >= DOE_W'(DAYS_PER_CENT))
                  + 3'(doe3_r >= DOE_W'(2 * DAYS_PER_CENT))
                  + 3'(doe3_r >= DOE_W'(3 * DAYS_PER_CENT))
                  + 3'(doe3_r >= DOE_W'(ERA_LAST_DAY));

  // D5: year of era
  assign n_val    = doe4_r - DOE_W'(q4y4_r) + DOE_W'(cent4_r) - DOE_W'(last4_r);
  assign yoe_prod = 36'(n_val) * 36'(YEAR_RECIP);

  // D6: day of March-based year
  assign yoe_cent = 2'(yoe5_r >= YOE_W'(100)) + 2'(yoe5_r >= YOE_W'(200))
                  + 2'(yoe5_r >= YOE_W'(300));
  assign yoe_days = DOE_W'(yoe5_r) * DOE_W'(DAYS_PER_YEAR)
                  + DOE_W'(yoe5_r[YOE_W-1:2]) - DOE_W'(yoe_cent);
  assign doy_full = doe5_r - yoe_days;

  // D7: month index, (5*doy + 2) / 153
  assign mp_arg  = {doy6_r, 2'b00} + 11'(doy6_r) + 11'd2;
  assign mp_prod = 22'(mp_arg) * 22'(M153_RECIP);

  // D8: day, month and year rollover
  assign dom_full = doy7_r - month_start(mp7_r) + DOY_W'(1);
  assign jan_feb  = (mp7_r >= MP_JANUARY);
  assign mon_nxt  = jan_feb ? (mp7_r - MP_W'(9)) : (mp7_r + MP_W'(3));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      z1_r <= z_nxt;
    end
    if (en[1]) begin
      z2_r   <= z1_r;
      era2_r <= era_prod[ERA_SHIFT+ERA_W-1:ERA_SHIFT];
    end
    if (en[2]) begin
      doe3_r   <= doe_full[DOE_W-1:0];
      ybase3_r <= ybase_nxt;
    end
    if (en[3]) begin
      doe4_r   <= doe3_r;
      ybase4_r <= ybase3_r;
      q4y4_r   <= q4y_prod[Q4Y_SHIFT+6:Q4Y_SHIFT];
      cent4_r  <= cent_nxt;
      last4_r  <= (doe3_r == DOE_W'(ERA_LAST_DAY));
    end
    if (en[4]) begin
      doe5_r   <= doe4_r;
      ybase5_r <= ybase4_r;
      yoe5_r   <= yoe_prod[YEAR_SHIFT+YOE_W-1:YEAR_SHIFT];
    end
    if (en[5]) begin
      doy6_r   <= doy_full[DOY_W-1:0];
      yoe6_r   <= yoe5_r;
      ybase6_r <= ybase5_r;
    end
    if (en[6]) begin
      doy7_r  <= doy6_r;
      mp7_r   <= mp_prod[M153_SHIFT+MP_W-1:M153_SHIFT];
      ysum7_r <= ybase6_r + YEAR_W'(yoe6_r);
    end
    if (en[7]) begin
      ymd8_r.year         <= ysum7_r + YEAR_W'(jan_feb);
      ymd8_r.month        <= mon_nxt;
      ymd8_r.day_of_month <= dom_full[DOM_W-1:0];
    end
  end

  assign ymd_o = ymd8_r;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seconds-to-calendar converter. A directed set
// of dates (leap days, century years, Jan 1 of leap years, the clamp at the
// end of year 9999) is followed by random words weighted toward month ends.
// Every word taken at the input is converted by a local model and queued;
// every word leaving the block is checked field by field against it.
// ----------------------------------------------------------------------------
module tb;
  import esc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  esc_chan_if #(.payload_t(in_word_t))  in_if  ();
  esc_chan_if #(.payload_t(out_word_t)) out_if ();

  epoch_seconds_to_calendar_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #10 clk = ~clk;

  in_word_t  pending_words[$];   // words waiting to be offered
  out_word_t expected_dates[$];  // conversions of words already taken
  out_word_t want;

  int  tx_idle_pct;
  int  rx_idle_pct;
  int  stall_requests;
  int  stall_served;
  int  stall_left;
  int  errors;
  int  words_taken;
  int  results_checked;
  int  clamped_words;
  int  leap_days_seen;
  logic in_taken;

  // Conversion of one input word to its calendar date and time of day
  function automatic out_word_t civil_time_of(input in_word_t w);
    longint unsigned secs, day_num, sod, z, era, doe, yoe, doy, mp, mon, yr;
    out_word_t r;
    secs = w.epoch_seconds;
    if (secs > MAX_EPOCH_SECONDS) secs = MAX_EPOCH_SECONDS;
    day_num = secs / SECS_PER_DAY;
    sod     = secs % SECS_PER_DAY;
    // count from March 1 of year 0 so the leap day closes each year
    z   = day_num + EPOCH_SHIFT_DAYS;
    era = z / DAYS_PER_ERA;
    doe = z - era * DAYS_PER_ERA;
    yoe = (doe - doe / 1460 + doe / DAYS_PER_CENT - doe / ERA_LAST_DAY) / DAYS_PER_YEAR;
    doy = doe - (DAYS_PER_YEAR * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    yr  = yoe + era * YEARS_PER_ERA + ((mon <= 2) ? 1 : 0);
    r.year            = yr[YEAR_W-1:0];
    r.month           = mon[MON_W-1:0];
    r.day_of_month    = 5'(doy - (153 * mp + 2) / 5 + 1);
    r.hour            = 5'(sod / 3600);
    r.minute          = 6'((sod / SECS_PER_MIN) % MINS_PER_HOUR);
    r.second          = 6'(sod % SECS_PER_MIN);
    r.nanoseconds_out = w.nanoseconds;
    return r;
  endfunction

  // Seconds since the epoch for a given date and time (stimulus only)
  function automatic longint unsigned epoch_at(input int y, input int m, input int d,
                                               input int hh, input int mm, input int ss);
    longint yy, era, yoe, doy, doe, days;
    yy   = (m <= 2) ? y - 1 : y;
    era  = yy / 400;
    yoe  = yy - era * 400;
    doy  = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    return days * 86400 + hh * 3600 + mm * 60 + ss;
  endfunction

  task automatic queue_word(input longint unsigned secs, input logic [NS_W-1:0] ns);
    in_word_t w;
    w.epoch_seconds = secs[SECS_W-1:0];
    w.nanoseconds   = ns;
    pending_words.push_back(w);
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Random words: mostly in range, many near a month change, some clamped
  task automatic queue_random(input int count);
    logic [63:0] r64;
    longint unsigned secs, back;
    logic [NS_W-1:0] ns;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        do begin
          r64  = {$urandom, $urandom};
          secs = r64[SECS_W-1:0];
        end while (secs > MAX_EPOCH_SECONDS);
      end else if (sel < 85) begin
        secs = epoch_at($urandom_range(1970, 9999), $urandom_range(1, 12), 1, 0, 0, 0);
        back = $urandom_range(0, 2 * SECS_PER_DAY);
        secs = (secs >= back) ? secs - back : secs + back;
      end else begin
        r64  = {$urandom, $urandom};
        secs = r64[SECS_W-1:0];
      end
      if ($urandom_range(0, 99) < 85) ns = NS_W'($urandom_range(0, 999999999));
      else ns = NS_W'($urandom);
      queue_word(secs, ns);
    end
  endtask

  // Hold until nothing is pending, offered or outstanding
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_if.valid || expected_dates.size() != 0)
      @(negedge clk);
  endtask

  // Sender: offers queued words, holds each until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data  <= pending_words.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure plus an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served++;
      stall_left = 79;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Monitor: queue conversions of taken words, check words delivered
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        expected_dates.push_back(civil_time_of(in_if.data));
        words_taken++;
        if (in_if.data.epoch_seconds > MAX_EPOCH_SECONDS) clamped_words++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_dates.size() == 0) begin
          $error("result word with no input outstanding");
          errors++;
        end else begin
          want = expected_dates.pop_front();
          results_checked++;
          if (want.month == 2 && want.day_of_month == 29) leap_days_seen++;
          check_field("year",            want.year,            out_if.data.year);
          check_field("month",           want.month,           out_if.data.month);
          check_field("day_of_month",    want.day_of_month,    out_if.data.day_of_month);
          check_field("hour",            want.hour,            out_if.data.hour);
          check_field("minute",          want.minute,          out_if.data.minute);
          check_field("second",          want.second,          out_if.data.second);
          check_field("nanoseconds_out", want.nanoseconds_out, out_if.data.nanoseconds_out);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #10ms;
    $display("epoch_seconds_to_calendar_top verification failed");
    $finish;
  end

  // Sequence of test phases
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    tx_idle_pct    = 35;
    rx_idle_pct    = 77;
    stall_requests = 0;
    stall_served   = 0;
    stall_left     = 0;
    errors         = 0;
    words_taken    = 0;
    results_checked = 0;
    clamped_words  = 0;
    leap_days_seen = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed dates: epoch start, leap rules, century years, clamp
    queue_word(0, 0);
    queue_word(0, {NS_W{1'b1}});
    queue_word(epoch_at(1970, 1, 1, 23, 59, 59), 999999999);
    queue_word(epoch_at(1972, 1, 1, 0, 0, 0), 1);
    queue_word(epoch_at(1972, 2, 29, 12, 34, 56), 500000000);
    queue_word(epoch_at(1972, 12, 31, 23, 59, 59), 0);
    queue_word(epoch_at(1973, 1, 1, 0, 0, 0), 0);
    queue_word(epoch_at(1999, 12, 31, 23, 59, 59), 123456789);
    queue_word(epoch_at(2000, 1, 1, 0, 0, 0), 0);
    queue_word(epoch_at(2000, 2, 29, 0, 0, 0), 0);
    queue_word(epoch_at(2000, 3, 1, 0, 0, 0), 0);
    queue_word(epoch_at(2000, 12, 31, 23, 59, 59), 0);
    queue_word(epoch_at(2038, 1, 19, 3, 14, 7), 0);
    queue_word(epoch_at(2100, 2, 28, 23, 59, 59), 0);
    queue_word(epoch_at(2100, 3, 1, 0, 0, 0), 0);
    queue_word(epoch_at(2400, 2, 29, 6, 0, 0), 0);
    queue_word(epoch_at(2400, 1, 1, 0, 0, 0), 0);
    queue_word(epoch_at(9999, 12, 31, 23, 59, 58), 0);
    queue_word(MAX_EPOCH_SECONDS, 999999999);
    queue_word(MAX_EPOCH_SECONDS + 1, 1000000000);
    queue_word(longint'(1) << 37, 1 << 29);
    queue_word((longint'(1) << SECS_W) - 1, {NS_W{1'b1}});
    wait_drained();

    // long output hold-off while the sender streams, to fill the pipeline
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(60);
    stall_requests++;
    wait_drained();

    tx_idle_pct = 35;
    rx_idle_pct = 77;
    queue_random(360);
    wait_drained();

    tx_idle_pct = 77;
    rx_idle_pct = 35;
    queue_random(360);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(360);
    wait_drained();

    repeat (2 * PIPE_STAGES) @(negedge clk);
    if (expected_dates.size() != 0) begin
      $error("%0d results never arrived", expected_dates.size());
      errors++;
    end

    $display("Converted %0d words, checked %0d results, %0d clamped past year 9999,",
             words_taken, results_checked, clamped_words);
    $display("%0d results on Feb 29; %0d mismatches.", leap_days_seen, errors);
    if (errors == 0) begin
      $display("epoch_seconds_to_calendar_top verification clean");
    end else begin
      $display("epoch_seconds_to_calendar_top verification failed");
    end
    $finish;
  end

endmodule
